// ===== src/dll_pkg.sv =====
`default_nettype none

package dll_pkg;

  localparam int unsigned NODES_DEF  = 16;
  localparam int unsigned DATA_W_DEF = 32;
  localparam int unsigned FUNC_W     = 4;
  localparam int unsigned WORD_W     = 32;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_HEAD  = 4'd0,
    OP_PUSH_TAIL  = 4'd1,
    OP_POP_HEAD   = 4'd2,
    OP_POP_TAIL   = 4'd3,
    OP_PEEK_HEAD  = 4'd4,
    OP_PEEK_TAIL  = 4'd5,
    OP_CUR_HEAD   = 4'd6,
    OP_CUR_TAIL   = 4'd7,
    OP_CUR_READ   = 4'd8,
    OP_STEP_BACK  = 4'd9,
    OP_STEP_FWD   = 4'd10,
    OP_INS_BEFORE = 4'd11,
    OP_INS_AFTER  = 4'd12,
    OP_DEL_BEFORE = 4'd13,
    OP_DEL_AFTER  = 4'd14,
    OP_CLEAR      = 4'd15
  } func_e;

endpackage

`default_nettype wire

// ===== src/doubly_linked_list_engine.sv =====
`default_nettype none
// an accepted request passes S_RD2, S_EXE and S_WR2, and waits in S_HOLD if the result stalls
// a new request is taken only back in S_IDLE, set by two dependent read rounds and two write
//   rounds on the link memories (prev and next), each with a single write port
// reset: head, tail, cursor and free list go null, fresh count goes to zero;
//   the pool memories are not cleared, so the block is ready right after reset

module doubly_linked_list_engine #(
  parameter int unsigned NODES  = dll_pkg::NODES_DEF,
  parameter int unsigned DATA_W = dll_pkg::DATA_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dll_pkg::FUNC_W-1:0] func_i,
  input  logic [dll_pkg::WORD_W-1:0] payload_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      status_o,
  output logic [dll_pkg::WORD_W-1:0] payload_out_o,
  output logic                      list_empty_o,
  output logic                      cursor_valid_o
);

  import dll_pkg::*;

  localparam int unsigned IDX_W = $clog2(NODES + 1);
  localparam int unsigned AW    = $clog2(NODES);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD2  = 5'b00010,
    S_EXE  = 5'b00100,
    S_WR2  = 5'b01000,
    S_HOLD = 5'b10000
  } state_e;

  function automatic logic is_node(input logic [IDX_W-1:0] x);
    return x < NIL;
  endfunction

  state_e state_q, state_d;

  // list registers
  logic [IDX_W-1:0] head_q, tail_q, cursor_q, free_q, fresh_q;
  logic [IDX_W-1:0] head_d, tail_d, cursor_d, free_d, fresh_d;
  logic [IDX_W-1:0] hd, tl, c;

  // per-request working registers
  func_e             op_q;
  logic [DATA_W-1:0] word_q;
  logic [IDX_W-1:0]  n1_q, n2_q, p1_q, q1_q;
  logic [DATA_W-1:0] w1_q;
  logic [IDX_W-1:0]  n1, n2;

  // memory ports
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  prev_rd, next_rd;
  logic [DATA_W-1:0] pay_rd;
  logic              prev_we, next_we;
  logic [IDX_W-1:0]  prev_wa, next_wa, prev_wd, next_wd;

  // first write round
  logic              pay_we_a;
  logic [IDX_W-1:0]  pay_wa_a;
  logic              prev_we_a, next_we_a;
  logic [IDX_W-1:0]  prev_wa_a, prev_wd_a, next_wa_a, next_wd_a;

  // second write round, held for the cycle after execute
  logic              prev_we_b_q, next_we_b_q, prev_we_b_d, next_we_b_d;
  logic [IDX_W-1:0]  prev_wa_b_q, prev_wd_b_q, next_wa_b_q, next_wd_b_q;
  logic [IDX_W-1:0]  prev_wa_b_d, prev_wd_b_d, next_wa_b_d, next_wd_b_d;

  // result
  logic              bad;
  logic [DATA_W-1:0] res;
  logic              st_q, emp_q, cv_q;
  logic [WORD_W-1:0] po_q;
  logic              out_valid_q, out_st_q, out_emp_q, out_cv_q;
  logic [WORD_W-1:0] out_po_q;
  logic              out_free, out_load, accept;

  // place / remove helpers
  logic              pl_en, rm_en;
  logic [IDX_W-1:0]  pl_p, pl_q, rm_n, rm_p, rm_q, alloc_n;
  logic [DATA_W-1:0] rm_w;

  assign hd = (is_node(head_q) && is_node(tail_q)) ? head_q : NIL;
  assign tl = (is_node(head_q) && is_node(tail_q)) ? tail_q : NIL;
  assign c  = is_node(cursor_q) ? cursor_q : NIL;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = ((state_q == S_WR2) || (state_q == S_HOLD)) && out_free;

  // first read node, from the incoming operation
  always_comb begin
    unique case (func_e'(func_i))
      OP_POP_HEAD, OP_PEEK_HEAD, OP_CUR_HEAD: n1 = hd;
      OP_POP_TAIL, OP_PEEK_TAIL, OP_CUR_TAIL: n1 = tl;
      default:                                n1 = c;
    endcase
  end

  // second read node: the cursor's neighbour, or the free-list head for allocation
  always_comb begin
    unique case (op_q)
      OP_STEP_BACK, OP_DEL_BEFORE: n2 = prev_rd;
      OP_STEP_FWD, OP_DEL_AFTER:   n2 = next_rd;
      default:                     n2 = free_q;
    endcase
  end

  assign rd_en   = accept || (state_q == S_RD2);
  assign rd_addr = accept ? n1 : n2;

  assign alloc_n = is_node(free_q) ? free_q : (is_node(fresh_q) ? fresh_q : NIL);

  always_comb begin
    bad         = 1'b0;
    res         = '0;
    head_d      = hd;
    tail_d      = tl;
    cursor_d    = c;
    free_d      = free_q;
    fresh_d     = fresh_q;
    pay_we_a    = 1'b0;
    pay_wa_a    = alloc_n;
    prev_we_a   = 1'b0;
    prev_wa_a   = NIL;
    prev_wd_a   = NIL;
    next_we_a   = 1'b0;
    next_wa_a   = NIL;
    next_wd_a   = NIL;
    prev_we_b_d = 1'b0;
    prev_wa_b_d = NIL;
    prev_wd_b_d = NIL;
    next_we_b_d = 1'b0;
    next_wa_b_d = NIL;
    next_wd_b_d = NIL;
    pl_en       = 1'b0;
    pl_p        = NIL;
    pl_q        = NIL;
    rm_en       = 1'b0;
    rm_n        = NIL;
    rm_p        = NIL;
    rm_q        = NIL;
    rm_w        = '0;

    unique case (op_q)
      OP_PUSH_HEAD: begin
        pl_en = 1'b1;
        pl_q  = hd;
      end
      OP_PUSH_TAIL: begin
        pl_en = 1'b1;
        pl_p  = tl;
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        if (!is_node(n1_q)) begin
          bad = 1'b1;
        end else begin
          rm_en = 1'b1;
          rm_n  = n1_q;
          rm_p  = p1_q;
          rm_q  = q1_q;
          rm_w  = w1_q;
        end
      end
      OP_PEEK_HEAD, OP_PEEK_TAIL, OP_CUR_READ: begin
        if (!is_node(n1_q)) bad = 1'b1;
        else res = w1_q;
      end
      OP_CUR_HEAD, OP_CUR_TAIL: begin
        cursor_d = n1_q;
        bad      = !is_node(n1_q);
      end
      OP_STEP_BACK, OP_STEP_FWD: begin
        if (!is_node(c) || !is_node(n2_q)) begin
          bad = 1'b1;
        end else begin
          cursor_d = n2_q;
          res      = pay_rd;
        end
      end
      OP_INS_BEFORE: begin
        if (!is_node(c)) begin
          bad = 1'b1;
        end else begin
          pl_en = 1'b1;
          pl_p  = p1_q;
          pl_q  = c;
        end
      end
      OP_INS_AFTER: begin
        if (!is_node(c)) begin
          bad = 1'b1;
        end else begin
          pl_en = 1'b1;
          pl_p  = c;
          pl_q  = q1_q;
        end
      end
      OP_DEL_BEFORE, OP_DEL_AFTER: begin
        if (!is_node(c) || !is_node(n2_q)) begin
          bad = 1'b1;
        end else begin
          rm_en = 1'b1;
          rm_n  = n2_q;
          rm_p  = prev_rd;
          rm_q  = next_rd;
          rm_w  = pay_rd;
        end
      end
      OP_CLEAR: begin
        // splice the whole list in front of the free list
        if (is_node(hd)) begin
          next_we_a = 1'b1;
          next_wa_a = tl;
          next_wd_a = free_q;
          free_d    = hd;
        end
        head_d   = NIL;
        tail_d   = NIL;
        cursor_d = NIL;
      end
      default: bad = 1'b1;
    endcase

    if (pl_en) begin
      if (!is_node(alloc_n)) begin
        bad = 1'b1;
      end else begin
        // the new node's own fields go first, neighbour links in the second round
        pay_we_a  = 1'b1;
        prev_we_a = 1'b1;
        prev_wa_a = alloc_n;
        prev_wd_a = pl_p;
        next_we_a = 1'b1;
        next_wa_a = alloc_n;
        next_wd_a = pl_q;
        if (is_node(pl_p)) begin
          next_we_b_d = 1'b1;
          next_wa_b_d = pl_p;
          next_wd_b_d = alloc_n;
        end else begin
          head_d = alloc_n;
        end
        if (is_node(pl_q)) begin
          prev_we_b_d = 1'b1;
          prev_wa_b_d = pl_q;
          prev_wd_b_d = alloc_n;
        end else begin
          tail_d = alloc_n;
        end
        // free-list head's next link came from the second read round
        if (is_node(free_q)) free_d = next_rd;
        else fresh_d = fresh_q + IDX_W'(1);
      end
    end

    if (rm_en) begin
      if (is_node(rm_p)) begin
        next_we_a = 1'b1;
        next_wa_a = rm_p;
        next_wd_a = rm_q;
      end else begin
        head_d = rm_q;
      end
      if (is_node(rm_q)) begin
        prev_we_a = 1'b1;
        prev_wa_a = rm_q;
        prev_wd_a = rm_p;
      end else begin
        tail_d = rm_p;
      end
      if (c == rm_n) cursor_d = NIL;
      next_we_b_d = 1'b1;
      next_wa_b_d = rm_n;
      next_wd_b_d = free_q;
      free_d      = rm_n;
      res         = rm_w;
    end

    if (bad) res = '0;
  end

  // memory write port muxing between the two write rounds
  always_comb begin
    prev_we = 1'b0;
    prev_wa = prev_wa_a;
    prev_wd = prev_wd_a;
    next_we = 1'b0;
    next_wa = next_wa_a;
    next_wd = next_wd_a;
    if (state_q == S_EXE) begin
      prev_we = prev_we_a && is_node(prev_wa_a);
      next_we = next_we_a && is_node(next_wa_a);
    end else if (state_q == S_WR2) begin
      prev_we = prev_we_b_q && is_node(prev_wa_b_q);
      prev_wa = prev_wa_b_q;
      prev_wd = prev_wd_b_q;
      next_we = next_we_b_q && is_node(next_wa_b_q);
      next_wa = next_wa_b_q;
      next_wd = next_wd_b_q;
    end
  end

  dll_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_EXE) && pay_we_a),
    .waddr_i (pay_wa_a[AW-1:0]),
    .wdata_i (word_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (pay_rd)
  );

  dll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_wa[AW-1:0]),
    .wdata_i (prev_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (prev_rd)
  );

  dll_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_wa[AW-1:0]),
    .wdata_i (next_wd),
    .re_i    (rd_en),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (next_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RD2;
      S_RD2:  state_d = S_EXE;
      S_EXE:  state_d = S_WR2;
      S_WR2:  state_d = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL;
      tail_q      <= NIL;
      cursor_q    <= NIL;
      free_q      <= NIL;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      prev_we_b_q <= 1'b0;
      next_we_b_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXE) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        cursor_q    <= cursor_d;
        free_q      <= free_d;
        fresh_q     <= fresh_d;
        prev_we_b_q <= prev_we_b_d;
        next_we_b_q <= next_we_b_d;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= func_e'(func_i);
      word_q <= DATA_W'(payload_in_i);
      n1_q   <= n1;
    end
    if (state_q == S_RD2) begin
      n2_q <= n2;
      p1_q <= prev_rd;
      q1_q <= next_rd;
      w1_q <= pay_rd;
    end
    if (state_q == S_EXE) begin
      prev_wa_b_q <= prev_wa_b_d;
      prev_wd_b_q <= prev_wd_b_d;
      next_wa_b_q <= next_wa_b_d;
      next_wd_b_q <= next_wd_b_d;
      st_q        <= bad;
      po_q        <= WORD_W'(res);
      emp_q       <= !is_node(head_d);
      cv_q        <= is_node(cursor_d);
    end
    if (out_load) begin
      out_st_q  <= st_q;
      out_po_q  <= po_q;
      out_emp_q <= emp_q;
      out_cv_q  <= cv_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign payload_out_o  = out_po_q;
  assign list_empty_o   = out_emp_q;
  assign cursor_valid_o = out_cv_q;

endmodule

`default_nettype wire

// ===== src/dll_ram.sv =====
`default_nettype none

module dll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
